FILE: rtl/ata_ts_pkg.sv
// shared types and constants for the ata task-file sequencer
// register selects, status codes, address modes and the decoded job record
// no dependencies
`default_nettype none

package ata_ts_pkg;

	// task-file register selects, in the order they are written
	localparam logic [3:0] SEL_CONTROL  = 4'd0;
	localparam logic [3:0] SEL_DEVICE   = 4'd1;
	localparam logic [3:0] SEL_COUNT_HI = 4'd2;
	localparam logic [3:0] SEL_LBA3     = 4'd3;
	localparam logic [3:0] SEL_LBA4     = 4'd4;
	localparam logic [3:0] SEL_LBA5     = 4'd5;
	localparam logic [3:0] SEL_COUNT_LO = 4'd6;
	localparam logic [3:0] SEL_LBA0     = 4'd7;
	localparam logic [3:0] SEL_LBA1     = 4'd8;
	localparam logic [3:0] SEL_LBA2     = 4'd9;
	localparam logic [3:0] SEL_COMMAND  = 4'd10;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ABSENT   = 2'd1;
	localparam logic [1:0] ST_NO_LBA48 = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DEVICE_PRESENT = 2'd0;
	localparam logic [1:0] CFG_LBA_CAPABLE    = 2'd1;
	localparam logic [1:0] CFG_SLAVE_DEVICE   = 2'd2;
	localparam logic [1:0] CFG_IRQ_DISABLED   = 2'd3;

	// ata command bytes
	localparam logic [7:0] CMD_READ      = 8'h20;
	localparam logic [7:0] CMD_READ_EXT  = 8'h24;
	localparam logic [7:0] CMD_WRITE     = 8'h30;
	localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

	localparam logic [7:0] NIEN_BIT   = 8'h02;
	localparam logic [7:0] DEV_LBA    = 8'hE0;
	localparam logic [7:0] DEV_CHS    = 8'hA0;
	localparam logic [7:0] DEV_SLAVE  = 8'h10;

	// divide by 63 for addresses below 2^28: q = (a * RECIP) >> SHIFT
	localparam int          CHS_SHIFT = 34;
	localparam logic [28:0] CHS_RECIP = 29'd272696337;
	localparam int          QUOT_W    = 22;

	typedef enum logic [2:0] {
		MODE_ABSENT,
		MODE_NO_LBA48,
		MODE_LBA48,
		MODE_LBA28,
		MODE_CHS
	} mode_t;

	typedef struct packed {
		logic device_present;
		logic lba_capable;
		logic slave_device;
		logic irq_disabled;
	} cfg_t;

	// everything the sequencer needs for one request
	typedef struct packed {
		mode_t      mode;
		logic [7:0] ctrl;
		logic [7:0] dev;
		logic [7:0] lba3;
		logic [7:0] count;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] cmd;
	} job_t;

endpackage

`default_nettype wire

FILE: rtl/ata_taskfile_sequencer.sv
// ata task-file sequencer top level: request register, configuration, decode, sequencer
// depends on ata_ts_pkg, ata_ts_decode and ata_ts_seq
//
// usage:
//   a request (func, block_address, sector_total) is taken at a rising edge
//   where start is high and busy is low. it becomes the ordered task-file
//   writes: 11 for lba48, 7 for lba28 or chs, 2 for a high address on a
//   drive without lba, 1 when no device is present.
//   each write appears on reg_select/reg_value/status/last for exactly one
//   cycle with strobe high; the receiver cannot stall, so results flow one
//   per cycle. last marks the final write of a request.
//   a request passes the request register, the sequencer's job slot and
//   the result register before its first write is on the ports; it waits
//   in the request register while an earlier request is still running.
//   the next request is taken while the current one is running and, if
//   it is waiting when the current one ends, its first write follows the
//   previous last write with no gap.
//   configuration: cfg_we writes cfg_data into register cfg_index
//   (0 device_present, 1 lba_capable, 2 slave_device, 3 irq_disabled)
//   and must only be used while idle.
//   reset clears all in-flight work; irq_disabled resets to 1, the rest to 0.
`default_nettype none

module ata_taskfile_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] block_address,
	input  wire logic [7:0]  sector_total,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic        cfg_data,
	output logic             strobe,
	output logic [3:0]       reg_select,
	output logic [7:0]       reg_value,
	output logic [1:0]       status,
	output logic             last
);
	import ata_ts_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic        func_s1;
	logic [31:0] addr_s1;
	logic [7:0]  count_s1;
	job_t        job_dec;
	logic        job_take;
	logic        accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_present <= 1'b0;
			cfg_q.lba_capable    <= 1'b0;
			cfg_q.slave_device   <= 1'b0;
			cfg_q.irq_disabled   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_PRESENT: cfg_q.device_present <= cfg_data;
				CFG_LBA_CAPABLE:    cfg_q.lba_capable    <= cfg_data;
				CFG_SLAVE_DEVICE:   cfg_q.slave_device   <= cfg_data;
				CFG_IRQ_DISABLED:   cfg_q.irq_disabled   <= cfg_data;
				default:            cfg_q.irq_disabled   <= cfg_q.irq_disabled;
			endcase
		end
	end

	// request register, freed when the sequencer takes its job
	assign busy   = valid_s1 && !job_take;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (job_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			addr_s1  <= block_address;
			count_s1 <= sector_total;
		end
	end

	// decode of the held request
	ata_ts_decode u_decode (
		.func          (func_s1),
		.block_address (addr_s1),
		.sector_total  (count_s1),
		.cfg           (cfg_q),
		.job           (job_dec)
	);

	// write sequencer and result register
	ata_ts_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (valid_s1),
		.job_in     (job_dec),
		.job_take   (job_take),
		.strobe     (strobe),
		.reg_select (reg_select),
		.reg_value  (reg_value),
		.status     (status),
		.last       (last)
	);

	// a held request moves on only into a free or finishing slot
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !job_take |=> valid_s1 && $stable(addr_s1))
		else $error("held request lost");

	// an accepted request is always pending in the next cycle
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request not registered");

	// nothing is taken from an empty request register
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> valid_s1)
		else $error("job taken from empty register");

endmodule

`default_nettype wire

FILE: rtl/ata_ts_decode.sv
// request decoder: picks the address mode and forms every register byte
// chs geometry via a reciprocal multiply by 1/63; uses ata_ts_pkg
`default_nettype none

module ata_ts_decode (
	input  wire logic              func,
	input  wire logic [31:0]       block_address,
	input  wire logic [7:0]        sector_total,
	input  wire ata_ts_pkg::cfg_t  cfg,
	output ata_ts_pkg::job_t       job
);
	import ata_ts_pkg::*;

	logic [56:0]       prod;
	logic [QUOT_W-1:0] quot;
	logic [5:0]        rem;
	logic [3:0]        head;
	logic [15:0]       cyl;
	logic [7:0]        sec;
	logic [7:0]        slave_bit;
	logic              high_addr;

	// low 22 bits of the quotient by 63, exact for 28-bit addresses
	assign prod = 57'(block_address[27:0]) * 57'(CHS_RECIP);
	assign quot = prod[CHS_SHIFT +: QUOT_W];

	// addr = 63q + r, so r = (addr + q) mod 64
	assign rem  = block_address[5:0] + quot[5:0];
	assign sec  = {2'b00, rem} + 8'd1;
	assign head = quot[3:0];
	assign cyl  = quot[19:4];

	assign slave_bit = cfg.slave_device ? DEV_SLAVE : 8'h00;
	assign high_addr = |block_address[31:28];

	// mode select and byte formation
	always_comb begin
		job.ctrl  = cfg.irq_disabled ? NIEN_BIT : 8'h00;
		job.count = sector_total;
		job.lba3  = block_address[31:24];
		job.b0    = block_address[7:0];
		job.b1    = block_address[15:8];
		job.b2    = block_address[23:16];
		job.dev   = DEV_LBA | slave_bit | {4'h0, block_address[27:24]};
		job.cmd   = func ? CMD_WRITE : CMD_READ;
		if (!cfg.device_present) begin
			job.mode = MODE_ABSENT;
		end else if (high_addr) begin
			job.mode = cfg.lba_capable ? MODE_LBA48 : MODE_NO_LBA48;
			job.dev  = DEV_LBA | slave_bit;
			job.cmd  = func ? CMD_WRITE_EXT : CMD_READ_EXT;
		end else if (cfg.lba_capable) begin
			job.mode = MODE_LBA28;
		end else begin
			job.mode = MODE_CHS;
			job.dev  = DEV_CHS | slave_bit | {4'h0, head};
			job.b0   = sec;
			job.b1   = cyl[7:0];
			job.b2   = cyl[15:8];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ata_ts_seq.sv
// write sequencer: holds one decoded job and emits one register write per cycle
// results leave through a registered output stage; uses ata_ts_pkg
`default_nettype none

module ata_ts_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	input  wire ata_ts_pkg::job_t  job_in,
	output logic                   job_take,
	output logic                   strobe,
	output logic [3:0]             reg_select,
	output logic [7:0]             reg_value,
	output logic [1:0]             status,
	output logic                   last
);
	import ata_ts_pkg::*;

	job_t       job_s2;
	logic       valid_s2;
	logic [3:0] step_q;

	logic [3:0] sel;
	logic [7:0] val;
	logic [1:0] st;
	logic       fin;

	// pick the write for the current step
	always_comb begin
		sel = SEL_CONTROL;
		st  = ST_OK;
		fin = 1'b0;
		unique case (job_s2.mode) inside
			MODE_ABSENT: begin
				st  = ST_ABSENT;
				fin = 1'b1;
			end
			MODE_NO_LBA48: begin
				if (step_q != 4'd0) begin
					st  = ST_NO_LBA48;
					fin = 1'b1;
				end
			end
			MODE_LBA48: begin
				sel = step_q;
				fin = (step_q == SEL_COMMAND);
			end
			MODE_LBA28, MODE_CHS: begin
				sel = (step_q < SEL_COUNT_HI) ? step_q : step_q + 4'd4;
				fin = (sel == SEL_COMMAND);
			end
			default: begin
				st  = ST_ABSENT;
				fin = 1'b1;
			end
		endcase
	end

	// byte for the selected register
	always_comb begin
		case (sel)
			SEL_CONTROL:  val = job_s2.ctrl;
			SEL_DEVICE:   val = job_s2.dev;
			SEL_LBA3:     val = job_s2.lba3;
			SEL_COUNT_LO: val = job_s2.count;
			SEL_LBA0:     val = job_s2.b0;
			SEL_LBA1:     val = job_s2.b1;
			SEL_LBA2:     val = job_s2.b2;
			SEL_COMMAND:  val = job_s2.cmd;
			default:      val = 8'h00;
		endcase
		if (st != ST_OK) begin
			val = 8'h00;
		end
	end

	// next job may enter when the slot is empty or finishing now
	assign job_take = job_valid && (!valid_s2 || fin);

	// job slot and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			step_q   <= 4'd0;
		end else if (job_take) begin
			valid_s2 <= 1'b1;
			step_q   <= 4'd0;
		end else if (valid_s2) begin
			if (fin) begin
				valid_s2 <= 1'b0;
				step_q   <= 4'd0;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_s2 <= job_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		reg_select <= sel;
		reg_value  <= val;
		status     <= st;
		last       <= fin;
	end

	// an error result always closes the run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != ST_OK) |-> last)
		else $error("error result without last");

	// a run is never interrupted between its writes
	a_run_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a run");

	// an active job produces a result in the next cycle
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |=> strobe)
		else $error("active job emitted nothing");

	// the step counter never passes the command write
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= SEL_COMMAND)
		else $error("step counter out of range");

endmodule

`default_nettype wire

FILE: tb/ata_taskfile_sequencer_tb.sv
// self-checking testbench for ata_taskfile_sequencer: a directed table, then random requests
// under random configurations, checked against an in-bench model of the task-file write order
// depends on ata_ts_pkg and ata_taskfile_sequencer
`default_nettype none

module ata_taskfile_sequencer_tb;
	import ata_ts_pkg::*;

	localparam logic [31:0] LBA48_BASE  = 32'h1000_0000;
	localparam int          CHS_SECTORS = 63;
	localparam int          CHS_TRACKS  = 16 * 63;
	localparam int          STALL_LIMIT = 200;
	localparam int          NUM_PHASES  = 6;
	localparam int          PHASE_ITEMS = 15;
	localparam int          NUM_ROWS    = 21;

	// one task-file register write as seen on the result ports
	typedef struct packed {
		logic [3:0] sel;
		logic [7:0] val;
		logic [1:0] st;
		logic       fin;
	} tf_write_t;

	// directed row: config nibble {present, lba, slave, irq_off}, request, optional typed error
	typedef struct packed {
		logic [3:0]  cfg;
		logic        wr;
		logic [31:0] addr;
		logic [7:0]  cnt;
		logic        typed;
		logic [1:0]  err;
		logic [7:0]  ctrl;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        func = 1'b0;
	logic [31:0] block_address = '0;
	logic [7:0]  sector_total = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic        cfg_data = 1'b0;
	wire logic       busy;
	wire logic       strobe;
	wire logic [3:0] reg_select;
	wire logic [7:0] reg_value;
	wire logic [1:0] status;
	wire logic       last;

	ata_taskfile_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.block_address (block_address),
		.sector_total  (sector_total),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.reg_select    (reg_select),
		.reg_value     (reg_value),
		.status        (status),
		.last          (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model copy of the configuration registers
	logic model_present = 1'b0;
	logic model_lba     = 1'b0;
	logic model_slave   = 1'b0;
	logic model_irq_off = 1'b1;
	logic [3:0] cur_cfg = 4'b0001;

	tf_write_t pending_writes [$];
	int errors = 0;
	int requests_sent = 0;
	int writes_checked = 0;
	int mode_hits [5] = '{default: 0};

	dir_row_t dir_rows [0:NUM_ROWS-1] = '{
		// after reset: no device
		'{4'b0001, 1'b0, 32'h0000_0000, 8'h00, 1'b1, ST_ABSENT, 8'h00},
		'{4'b0001, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_ABSENT, 8'h00},
		// lba drive, master, interrupts off
		'{4'b1101, 1'b0, 32'h0000_0000, 8'h01, 1'b0, ST_OK, 8'h00},
		'{4'b1101, 1'b1, 32'h0FFF_FFFF, 8'hFF, 1'b0, ST_OK, 8'h00},
		'{4'b1101, 1'b0, 32'h1000_0000, 8'h00, 1'b0, ST_OK, 8'h00},
		'{4'b1101, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b0, ST_OK, 8'h00},
		// lba drive, slave, interrupts on
		'{4'b1110, 1'b0, 32'h0A5A_5A5A, 8'h80, 1'b0, ST_OK, 8'h00},
		'{4'b1110, 1'b1, 32'hF0F0_F0F0, 8'h7F, 1'b0, ST_OK, 8'h00},
		'{4'b1110, 1'b1, 32'h05A5_A5A5, 8'h01, 1'b0, ST_OK, 8'h00},
		// chs drive, master: sector, head and cylinder edges, cylinder wrap
		'{4'b1001, 1'b0, 32'd0,        8'h01, 1'b0, ST_OK, 8'h00},
		'{4'b1001, 1'b1, 32'd62,       8'h02, 1'b0, ST_OK, 8'h00},
		'{4'b1001, 1'b0, 32'd63,       8'h03, 1'b0, ST_OK, 8'h00},
		'{4'b1001, 1'b0, 32'd1007,     8'h04, 1'b0, ST_OK, 8'h00},
		'{4'b1001, 1'b1, 32'd1008,     8'h05, 1'b0, ST_OK, 8'h00},
		'{4'b1001, 1'b0, 32'h0FFF_FFFF, 8'hFE, 1'b0, ST_OK, 8'h00},
		'{4'b1001, 1'b1, 32'h1000_0000, 8'h10, 1'b1, ST_NO_LBA48, NIEN_BIT},
		'{4'b1001, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_NO_LBA48, NIEN_BIT},
		// chs drive, slave, interrupts on: cylinder just past the 16-bit wrap
		'{4'b1010, 1'b1, 32'd66061287, 8'h55, 1'b0, ST_OK, 8'h00},
		'{4'b1010, 1'b0, 32'h8000_0000, 8'h00, 1'b1, ST_NO_LBA48, 8'h00},
		'{4'b1010, 1'b1, 32'h0000_FFFF, 8'hAA, 1'b0, ST_OK, 8'h00},
		// absent device with lba and slave set, interrupts on
		'{4'b0110, 1'b1, 32'h1234_5678, 8'h99, 1'b1, ST_ABSENT, 8'h00}
	};

	function automatic void queue_write(logic [3:0] sel, logic [7:0] val, logic [1:0] st,
			logic fin);
		tf_write_t w;
		w = '{sel: sel, val: val, st: st, fin: fin};
		pending_writes.push_back(w);
	endfunction

	// expected task-file writes for one request under the current configuration
	function automatic mode_t predict_taskfile_writes(logic wr, logic [31:0] addr,
			logic [7:0] cnt);
		logic [7:0]  slave_bit;
		logic [7:0]  b0, b1, b2, cmd;
		logic [31:0] sector, base, cyl, head;
		mode_t       mode;
		slave_bit = model_slave ? DEV_SLAVE : 8'h00;
		if (!model_present) begin
			queue_write(SEL_CONTROL, 8'h00, ST_ABSENT, 1'b1);
			return MODE_ABSENT;
		end
		queue_write(SEL_CONTROL, model_irq_off ? NIEN_BIT : 8'h00, ST_OK, 1'b0);
		if (addr >= LBA48_BASE) begin
			if (!model_lba) begin
				queue_write(SEL_CONTROL, 8'h00, ST_NO_LBA48, 1'b1);
				return MODE_NO_LBA48;
			end
			queue_write(SEL_DEVICE, DEV_LBA | slave_bit, ST_OK, 1'b0);
			queue_write(SEL_COUNT_HI, 8'h00, ST_OK, 1'b0);
			queue_write(SEL_LBA3, addr[31:24], ST_OK, 1'b0);
			queue_write(SEL_LBA4, 8'h00, ST_OK, 1'b0);
			queue_write(SEL_LBA5, 8'h00, ST_OK, 1'b0);
			{b2, b1, b0} = addr[23:0];
			cmd = wr ? CMD_WRITE_EXT : CMD_READ_EXT;
			mode = MODE_LBA48;
		end else if (model_lba) begin
			queue_write(SEL_DEVICE, DEV_LBA | slave_bit | {4'h0, addr[27:24]}, ST_OK, 1'b0);
			{b2, b1, b0} = addr[23:0];
			cmd = wr ? CMD_WRITE : CMD_READ;
			mode = MODE_LBA28;
		end else begin
			// chs: 63 sectors per track, 16 heads, cylinder cut to 16 bits
			sector = addr % CHS_SECTORS + 1;
			base   = addr - (sector - 1);
			cyl    = (base / CHS_TRACKS) & 32'h0000_FFFF;
			head   = (base % CHS_TRACKS) / CHS_SECTORS;
			queue_write(SEL_DEVICE, DEV_CHS | slave_bit | {4'h0, head[3:0]}, ST_OK, 1'b0);
			b0 = sector[7:0];
			b1 = cyl[7:0];
			b2 = cyl[15:8];
			cmd = wr ? CMD_WRITE : CMD_READ;
			mode = MODE_CHS;
		end
		queue_write(SEL_COUNT_LO, cnt, ST_OK, 1'b0);
		queue_write(SEL_LBA0, b0, ST_OK, 1'b0);
		queue_write(SEL_LBA1, b1, ST_OK, 1'b0);
		queue_write(SEL_LBA2, b2, ST_OK, 1'b0);
		queue_write(SEL_COMMAND, cmd, ST_OK, 1'b1);
		return mode;
	endfunction

	// request transaction: optional idle gap, then hold start until busy is low at an edge
	task automatic send_request(logic wr, logic [31:0] addr, logic [7:0] cnt, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= wr;
		block_address <= addr;
		sector_total <= cnt;
		@(posedge clk);
		while (busy) @(posedge clk);
		requests_sent++;
	endtask

	// stop issuing, then let every expected write drain and the ports go quiet
	task automatic settle();
		start <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// write all four registers, one per cycle; nibble is {present, lba, slave, irq_off}
	task automatic write_config(logic [3:0] cfg);
		logic [1:0] idx [4];
		idx = '{CFG_DEVICE_PRESENT, CFG_LBA_CAPABLE, CFG_SLAVE_DEVICE, CFG_IRQ_DISABLED};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= cfg[3-i];
			@(posedge clk);
			case (idx[i])
				CFG_DEVICE_PRESENT: model_present = cfg[3-i];
				CFG_LBA_CAPABLE:    model_lba = cfg[3-i];
				CFG_SLAVE_DEVICE:   model_slave = cfg[3-i];
				CFG_IRQ_DISABLED:   model_irq_off = cfg[3-i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		cur_cfg = cfg;
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s expected 0x%0h got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// result checker: every strobed transaction against the oldest expectation
	always @(posedge clk) begin : check_writes
		tf_write_t want;
		if (arst_n && strobe) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected write: reg_select %0d reg_value 0x%02h status %0d last %0d",
					reg_select, reg_value, status, last);
				errors++;
			end else begin
				want = pending_writes.pop_front();
				check_field("reg_select", 8'(want.sel), 8'(reg_select));
				check_field("reg_value", want.val, reg_value);
				check_field("status", 8'(want.st), 8'(status));
				check_field("last", 8'(want.fin), 8'(last));
				writes_checked++;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	int stall_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : stimulus
		dir_row_t    row;
		mode_t       mode;
		logic [31:0] addr;
		logic [3:0]  cfg;
		bit          burst;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < NUM_ROWS; r++) begin
			row = dir_rows[r];
			if (row.cfg != cur_cfg) begin
				settle();
				write_config(row.cfg);
			end
			send_request(row.wr, row.addr, row.cnt, $urandom_range(0, 3) == 0 ? 0 :
				$urandom_range(0, 14));
			if (row.typed) begin
				if (row.err == ST_NO_LBA48) begin
					queue_write(SEL_CONTROL, row.ctrl, ST_OK, 1'b0);
					mode = MODE_NO_LBA48;
				end else
					mode = MODE_ABSENT;
				queue_write(SEL_CONTROL, 8'h00, row.err, 1'b1);
			end else
				mode = predict_taskfile_writes(row.wr, row.addr, row.cnt);
			mode_hits[int'(mode)]++;
		end

		// random phases, each under its own configuration
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			cfg = 4'($urandom);
			cfg[3] = ($urandom_range(0, 5) != 0);
			write_config(cfg);
			burst = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 5))
					0: addr = $urandom_range(0, 2000);
					1: addr = $urandom & 32'h0FFF_FFFF;
					2: addr = $urandom | LBA48_BASE;
					3: addr = LBA48_BASE + $urandom_range(0, 3) - 2;
					4: addr = $urandom;
					default: addr = 32'd66061287 + $urandom_range(0, 2000) - 1000;
				endcase
				send_request(1'($urandom), addr, 8'($urandom),
					burst ? 0 : $urandom_range(0, 14));
				mode = predict_taskfile_writes(func, addr, sector_total);
				mode_hits[int'(mode)]++;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("ran %0d requests, checked %0d task-file writes", requests_sent,
			writes_checked);
		$display("lba48 %0d, lba28 %0d, chs %0d, device absent %0d, lba48 refused %0d",
			mode_hits[int'(MODE_LBA48)], mode_hits[int'(MODE_LBA28)],
			mode_hits[int'(MODE_CHS)], mode_hits[int'(MODE_ABSENT)],
			mode_hits[int'(MODE_NO_LBA48)]);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/ata_ts_pkg.sv
rtl/ata_ts_decode.sv
rtl/ata_ts_seq.sv
rtl/ata_taskfile_sequencer.sv
tb/ata_taskfile_sequencer_tb.sv
